// File: rtl/dual_wildcard_signature_scan_defines.svh
// Assertion macros shared by the signature scanner RTL.
`ifndef DUAL_WILDCARD_SIGNATURE_SCAN_DEFINES_SVH
`define DUAL_WILDCARD_SIGNATURE_SCAN_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge out of reset.
`define DWS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication, checked on every clock edge out of reset.
`define DWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define DWS_ASSERT_NOW(label, ante, cons)
`define DWS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/dws_pkg.sv
// Shared types, constants and helper functions of the signature scanner.
package dws_pkg;

  localparam int PATTERN_BYTES_DEF = 16;
  localparam int HISTORY_DEPTH_DEF = 64;
  // Largest distance between the two pattern starts. The offset register
  // reaches one byte further below zero than above it.
  localparam int OFFSET_REACH      = 32;
  // Signed working width for window geometry.
  localparam int WIN_W             = 9;
  localparam int CFG_AW            = 6;
  localparam int CFG_DW            = 64;

  localparam logic [7:0] WILD_STAR  = 8'h2A;
  localparam logic [7:0] WILD_QUERY = 8'h3F;

  typedef enum logic [2:0] {
    REG_FIRST_LOW   = 3'd0,
    REG_FIRST_HIGH  = 3'd1,
    REG_FIRST_LEN   = 3'd2,
    REG_SECOND_LOW  = 3'd3,
    REG_SECOND_HIGH = 3'd4,
    REG_SECOND_LEN  = 3'd5,
    REG_SECOND_OFF  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] first_low;
    logic [63:0] first_high;
    logic [4:0]  first_len;
    logic [63:0] second_low;
    logic [63:0] second_high;
    logic [4:0]  second_len;
    logic [5:0]  second_off;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       region_end;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] match_position;
  } out_t;

  // Expected content of one history tap, one half for each pattern.
  typedef struct packed {
    logic       care_a;
    logic [7:0] byte_a;
    logic       care_b;
    logic [7:0] byte_b;
  } tap_t;

  // Window geometry: end minus one and full span minus one, in bytes.
  typedef struct packed {
    logic       usable;
    logic [7:0] lead_m1;
    logic [7:0] need_m1;
  } win_t;

  function automatic logic is_wild(input logic [7:0] b);
    return (b == WILD_STAR) || (b == WILD_QUERY);
  endfunction

  // Pattern bytes above the sixteen stored ones read as zero.
  function automatic logic [7:0] pat_byte(input logic [127:0] pat, input logic [4:0] idx);
    return idx[4] ? 8'h00 : pat[{idx[3:0], 3'b000} +: 8];
  endfunction

endpackage

// File: rtl/dual_wildcard_signature_scan.sv
// Top level of the dual wildcard signature scanner.
`include "dual_wildcard_signature_scan_defines.svh"

// The scanner takes one region byte per request and answers each region with
// exactly one result request: the region offset of the first position where
// the first pattern matches and the second pattern matches at the programmed
// signed distance, or a not-found result on the byte that carries region_end.
// Pattern bytes '*' and '?' match anything, a zero-length pattern never
// matches, and a window that reaches before the region start never matches.
// Once a match is reported the rest of that region stays silent. The block
// sustains one byte per clock unless out_ready holds a result back: a byte
// is shifted into a history line of min(HISTORY_DEPTH, PATTERN_BYTES + 32)
// taps, and in the following cycle all taps are compared at once against the
// expected bytes derived from the pattern registers; the single compare stage
// sets that rate. The compare outcome is registered in the result register,
// which drives out_valid until out_ready takes the result.
// While a result waits for out_ready, one more byte can be taken and held.
// Program the registers only while no region is in flight; there is no
// clearing pass after reset and the history needs none.
module dual_wildcard_signature_scan #(
  parameter int PATTERN_BYTES = dws_pkg::PATTERN_BYTES_DEF,
  parameter int HISTORY_DEPTH = dws_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  dws_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output dws_pkg::out_t              out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dws_pkg::CFG_AW-1:0] paddr,
  input  logic [dws_pkg::CFG_DW-1:0] pwdata,
  output logic [dws_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);

  // The widest window any register setting can ask for, capped by the history.
  localparam int WIN_MAX   = PATTERN_BYTES + dws_pkg::OFFSET_REACH;
  localparam int SHIFT_LEN = (HISTORY_DEPTH < WIN_MAX) ? HISTORY_DEPTH : WIN_MAX;

  dws_pkg::cfg_t                 cfg;
  dws_pkg::tap_t [SHIFT_LEN-1:0] taps;
  dws_pkg::win_t                 win;

  // History line: tap 0 is the byte held in the compare stage.
  logic [SHIFT_LEN-1:0][7:0] hist_r;

  logic          a_valid_r, a_valid_nxt;
  logic [31:0]   a_pos_r;
  logic          a_last_r;
  logic [31:0]   pos_r, pos_nxt;
  logic          rep_r, rep_nxt;
  logic          out_valid_r, out_valid_nxt;
  dws_pkg::out_t out_data_r, out_data_nxt;

  logic in_fire;
  logic out_free;
  logic adv;
  logic hit;
  logic emit_found;
  logic emit_none;

  dws_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dws_tap_template #(
    .PATTERN_BYTES (PATTERN_BYTES),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SHIFT_LEN     (SHIFT_LEN)
  ) u_tap_template (
    .cfg  (cfg),
    .taps (taps),
    .win  (win)
  );

  dws_window_cmp #(
    .SHIFT_LEN (SHIFT_LEN)
  ) u_window_cmp (
    .hist (hist_r),
    .taps (taps),
    .win  (win),
    .pos  (a_pos_r),
    .hit  (hit)
  );

  // The compare stage drains whenever the result register is free or
  // emptying this cycle, so a new byte can follow in every cycle.
  assign out_free  = !out_valid_r || out_ready;
  assign adv       = a_valid_r && out_free;
  assign in_ready  = !a_valid_r || out_free;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Only the first match of a region is reported; the last byte gives a
  // not-found answer if nothing was reported before it.
  assign emit_found = adv && !rep_r && hit;
  assign emit_none  = adv && !rep_r && !hit && a_last_r;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_fire) begin
      a_valid_nxt = 1'b1;
    end else if (adv) begin
      a_valid_nxt = 1'b0;
    end

    // Position of the next byte; it restarts after the last byte of a region
    // and wraps naturally at the top of its range.
    pos_nxt = pos_r;
    if (in_fire) begin
      pos_nxt = in_data.region_end ? '0 : pos_r + 32'd1;
    end

    rep_nxt = rep_r;
    if (adv) begin
      rep_nxt = a_last_r ? 1'b0 : (rep_r || hit);
    end

    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (emit_found) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.found          = 1'b1;
      out_data_nxt.match_position = a_pos_r - {24'd0, win.lead_m1};
    end else if (emit_none) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.found          = 1'b0;
      out_data_nxt.match_position = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      pos_r       <= '0;
      rep_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      pos_r       <= pos_nxt;
      rep_r       <= rep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      hist_r   <= {hist_r[SHIFT_LEN-2:0], in_data.data_byte};
      a_pos_r  <= pos_r;
      a_last_r <= in_data.region_end;
    end
    out_data_r <= out_data_nxt;
  end

  // A reported match inside a region silences the rest of it.
  `DWS_ASSERT_NEXT(a_found_sets_reported, emit_found && !a_last_r, rep_r)
  // A match never places the first pattern before the region start.
  `DWS_ASSERT_NOW(a_hit_inside_region, a_valid_r && hit, a_pos_r >= {24'd0, win.lead_m1})
  // A not-found result always carries a zero position.
  `DWS_ASSERT_NOW(a_none_zero_pos, out_valid_r && !out_data_r.found,
                  out_data_r.match_position == 32'd0)
  // The byte after a region end starts again at position zero.
  `DWS_ASSERT_NEXT(a_end_restarts_pos, in_fire && in_data.region_end, pos_r == 32'd0)

endmodule

// File: rtl/dws_cfg_regs.sv
// Configuration register file behind the APB-style port.
module dws_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dws_pkg::CFG_AW-1:0] paddr,
  input  logic [dws_pkg::CFG_DW-1:0] pwdata,
  output logic [dws_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output dws_pkg::cfg_t              cfg
);

  dws_pkg::cfg_t    cfg_r;
  dws_pkg::cfg_t    cfg_nxt;
  dws_pkg::reg_idx_t idx;
  logic             wr_en;

  assign idx    = dws_pkg::reg_idx_t'(paddr[dws_pkg::CFG_AW-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        dws_pkg::REG_FIRST_LOW:   cfg_nxt.first_low   = pwdata;
        dws_pkg::REG_FIRST_HIGH:  cfg_nxt.first_high  = pwdata;
        dws_pkg::REG_FIRST_LEN:   cfg_nxt.first_len   = pwdata[4:0];
        dws_pkg::REG_SECOND_LOW:  cfg_nxt.second_low  = pwdata;
        dws_pkg::REG_SECOND_HIGH: cfg_nxt.second_high = pwdata;
        dws_pkg::REG_SECOND_LEN:  cfg_nxt.second_len  = pwdata[4:0];
        dws_pkg::REG_SECOND_OFF:  cfg_nxt.second_off  = pwdata[5:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dws_pkg::REG_FIRST_LOW:   prdata = cfg_r.first_low;
      dws_pkg::REG_FIRST_HIGH:  prdata = cfg_r.first_high;
      dws_pkg::REG_FIRST_LEN:   prdata = {59'd0, cfg_r.first_len};
      dws_pkg::REG_SECOND_LOW:  prdata = cfg_r.second_low;
      dws_pkg::REG_SECOND_HIGH: prdata = cfg_r.second_high;
      dws_pkg::REG_SECOND_LEN:  prdata = {59'd0, cfg_r.second_len};
      dws_pkg::REG_SECOND_OFF:  prdata = {58'd0, cfg_r.second_off};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: rtl/dws_tap_template.sv
// Turns the pattern registers into per-tap expected bytes and window geometry.
module dws_tap_template #(
  parameter int PATTERN_BYTES = dws_pkg::PATTERN_BYTES_DEF,
  parameter int HISTORY_DEPTH = dws_pkg::HISTORY_DEPTH_DEF,
  parameter int SHIFT_LEN     = dws_pkg::PATTERN_BYTES_DEF + dws_pkg::OFFSET_REACH
) (
  input  dws_pkg::cfg_t                  cfg,
  output dws_pkg::tap_t [SHIFT_LEN-1:0]  taps,
  output dws_pkg::win_t                  win
);

  localparam int W = dws_pkg::WIN_W;
  localparam logic [5:0] PB = 6'(PATTERN_BYTES);

  logic [5:0]          len_a;
  logic [5:0]          len_b;
  logic signed [W-1:0] len_a_s;
  logic signed [W-1:0] len_b_s;
  logic signed [W-1:0] off_s;
  logic signed [W-1:0] reach_b;
  logic signed [W-1:0] end_s;
  logic signed [W-1:0] low_s;
  logic signed [W-1:0] span_s;
  logic [127:0]        pat_a;
  logic [127:0]        pat_b;

  assign pat_a = {cfg.first_high, cfg.first_low};
  assign pat_b = {cfg.second_high, cfg.second_low};

  always_comb begin
    // Lengths above the pattern capacity saturate.
    len_a   = ({1'b0, cfg.first_len} > PB) ? PB : {1'b0, cfg.first_len};
    len_b   = ({1'b0, cfg.second_len} > PB) ? PB : {1'b0, cfg.second_len};
    len_a_s = $signed({{(W-6){1'b0}}, len_a});
    len_b_s = $signed({{(W-6){1'b0}}, len_b});
    off_s   = $signed({{(W-6){cfg.second_off[5]}}, cfg.second_off});
    reach_b = off_s + len_b_s;
    end_s   = (reach_b > len_a_s) ? reach_b : len_a_s;
    low_s   = off_s[W-1] ? off_s : '0;
    span_s  = end_s - low_s;
    win.usable  = (len_a != '0) && (len_b != '0) &&
                  ({1'b0, span_s} <= (W+1)'(HISTORY_DEPTH));
    win.lead_m1 = 8'(end_s - $signed(W'(1)));
    win.need_m1 = 8'(span_s - $signed(W'(1)));
  end

  // Tap k holds the byte k places older than the newest one.
  for (genvar k = 0; k < SHIFT_LEN; k++) begin : g_tap
    logic signed [W-1:0] ia;
    logic signed [W-1:0] ib;
    logic                va;
    logic                vb;
    logic [7:0]          ba;
    logic [7:0]          bb;

    always_comb begin
      ia = end_s - $signed(W'(k + 1));
      ib = ia - off_s;
      va = !ia[W-1] && (ia < len_a_s);
      vb = !ib[W-1] && (ib < len_b_s);
      ba = dws_pkg::pat_byte(pat_a, ia[4:0]);
      bb = dws_pkg::pat_byte(pat_b, ib[4:0]);
      taps[k].care_a = va && !dws_pkg::is_wild(ba);
      taps[k].byte_a = ba;
      taps[k].care_b = vb && !dws_pkg::is_wild(bb);
      taps[k].byte_b = bb;
    end
  end

endmodule

// File: rtl/dws_window_cmp.sv
// Compares every history tap against its expected bytes in parallel.
module dws_window_cmp #(
  parameter int SHIFT_LEN = dws_pkg::PATTERN_BYTES_DEF + dws_pkg::OFFSET_REACH
) (
  input  logic [SHIFT_LEN-1:0][7:0]     hist,
  input  dws_pkg::tap_t [SHIFT_LEN-1:0] taps,
  input  dws_pkg::win_t                 win,
  input  logic [31:0]                   pos,
  output logic                          hit
);

  logic [SHIFT_LEN-1:0] tap_ok;

  for (genvar k = 0; k < SHIFT_LEN; k++) begin : g_cmp
    assign tap_ok[k] = (!taps[k].care_a || (hist[k] == taps[k].byte_a)) &&
                       (!taps[k].care_b || (hist[k] == taps[k].byte_b));
  end

  // The whole window must lie inside the region seen so far.
  assign hit = win.usable && (pos >= {24'd0, win.need_m1}) && (&tap_ok);

endmodule

// File: dv/dual_wildcard_signature_scan_tb.sv
// Self-checking testbench for the dual wildcard signature scanner.
`timescale 1ns / 1ps

// The testbench streams byte regions into the scanner and checks every result
// request against a predictor that runs alongside it.
//
// How it works:
// - A short directed part walks a table of bytes under a few fixed pattern
//   settings. These cover reset values, a plain two-pattern hit followed by
//   silence for the rest of its region, wildcards with a negative second
//   offset that would reach before the region start, and the length and
//   offset extremes on regions too short to hold a window. Rows whose outcome
//   is plain at a glance carry their expected result. All other rows use the
//   predictor.
// - A random part then programs a fresh random setting per phase and sends
//   whole regions. Most regions have both patterns planted at a random
//   position, and some of those get one byte broken afterwards. The rest is
//   filler drawn mostly from a tiny alphabet, so chance matches are common too.
// - Both sides idle at random, with some phases free of idling.
// - Settings are only reprogrammed once the scanner has drained.
module dual_wildcard_signature_scan_tb;

  localparam int PAT_BYTES    = dws_pkg::PATTERN_BYTES_DEF;
  localparam int HIST_DEPTH   = dws_pkg::HISTORY_DEPTH_DEF;
  localparam int DIR_ROWS     = 16;
  localparam int RANDOM_ITEMS = 700;
  // The scanner registers each byte, then its result, and can hold one more byte.
  // Waiting this long after the last result lets a silent byte clear as well.
  localparam int DRAIN_CYCLES = 6;

  // This says how a directed row is checked. Random rows always use the predictor.
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_MISS, CHK_HIT} chk_kind_t;

  typedef struct {
    int         phase;
    logic [7:0] data;
    logic       last;
    chk_kind_t  kind;
    logic [31:0] pos;
  } vector_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  dws_pkg::in_t               in_data = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  dws_pkg::out_t              out_data;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [dws_pkg::CFG_AW-1:0] paddr = '0;
  logic [dws_pkg::CFG_DW-1:0] pwdata = '0;
  logic [dws_pkg::CFG_DW-1:0] prdata;
  logic                       pready;

  // Side information driven together with each request. It tells the checker
  // how the directed row is meant to be checked.
  chk_kind_t   in_check = CHK_MODEL;
  logic [31:0] in_hit_pos = '0;

  // Predictor state. The history ring is only read at positions written in
  // the current region.
  dws_pkg::cfg_t cfg_now = '0;
  logic [7:0]    history [HIST_DEPTH];
  logic [31:0]   scan_pos = '0;
  logic          reported = 1'b0;

  dws_pkg::out_t awaited_results [$];
  int   fail_count = 0;
  int   sent_count = 0;
  bit   idle_on = 1'b1;
  int   ready_left = 0;

  // Directed settings, one per phase. Phase 0 keeps the reset values.
  dws_pkg::cfg_t dir_cfgs [6] = '{
    '{64'h0, 64'h0, 5'd0, 64'h0, 64'h0, 5'd0, 6'h00},
    // The first pattern is "AB". The second is "C", two bytes further on.
    '{64'h4241, 64'h0, 5'd2, 64'h43, 64'h0, 5'd1, 6'h02},
    // The first pattern is "*?", then 0xFF. The second is 0x00, one byte before it.
    '{64'hFF3F2A, 64'h0, 5'd3, 64'h00, 64'h0, 5'd1, 6'h3F},
    // Both lengths are above the limit, so they saturate. The offset is at its largest.
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31,
      64'h2A2A_2A2A_2A2A_2A2A, 64'h2A2A_2A2A_2A2A_2A2A, 5'd31, 6'h1F},
    // This phase has full-length all-wild patterns at an offset of -16.
    '{64'h3F3F_3F3F_3F3F_3F3F, 64'h3F3F_3F3F_3F3F_3F3F, 5'd16,
      64'h3F3F_3F3F_3F3F_3F3F, 64'h3F3F_3F3F_3F3F_3F3F, 5'd16, 6'h30},
    // The first pattern matches anything, but the second one is empty.
    '{64'h2A, 64'h0, 5'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 5'd0, 6'h05}
  };

  vector_t dir_rows [DIR_ROWS] = '{
    // With reset values both lengths are zero, so the region can only miss.
    '{0, 8'h00, 1'b0, CHK_NONE, 32'd0},
    '{0, 8'hFF, 1'b1, CHK_MISS, 32'd0},
    // "xABC" hits at offset 1 on the 'C'. The rest of the region stays quiet,
    // and no not-found result comes with its last byte.
    '{1, 8'h78, 1'b0, CHK_NONE, 32'd0},
    '{1, 8'h41, 1'b0, CHK_NONE, 32'd0},
    '{1, 8'h42, 1'b0, CHK_NONE, 32'd0},
    '{1, 8'h43, 1'b0, CHK_HIT,  32'd1},
    '{1, 8'h41, 1'b0, CHK_NONE, 32'd0},
    '{1, 8'h43, 1'b1, CHK_NONE, 32'd0},
    // At offset 0 the first pattern fits, but the second one would need a
    // byte before the region start. Offset 1 is the first hit.
    '{2, 8'h00, 1'b0, CHK_MODEL, 32'd0},
    '{2, 8'h11, 1'b0, CHK_MODEL, 32'd0},
    '{2, 8'hFF, 1'b0, CHK_MODEL, 32'd0},
    '{2, 8'hFF, 1'b1, CHK_HIT,  32'd1},
    // These regions are far too short for the window.
    '{3, 8'h00, 1'b0, CHK_NONE, 32'd0},
    '{3, 8'hFF, 1'b1, CHK_MISS, 32'd0},
    '{4, 8'h80, 1'b1, CHK_MISS, 32'd0},
    '{5, 8'h5A, 1'b1, CHK_MISS, 32'd0}
  };

  dual_wildcard_signature_scan dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Most gaps are zero or short, and a few are long. Phases with idling
  // switched off give back-to-back streams.
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic bit any_byte(input logic [7:0] b);
    return (b == dws_pkg::WILD_STAR) || (b == dws_pkg::WILD_QUERY);
  endfunction

  // Any length above the pattern storage counts as a full pattern.
  function automatic int eff_len(input logic [4:0] len);
    return (len > PAT_BYTES) ? PAT_BYTES : int'(len);
  endfunction

  function automatic bit window_fits(input logic [127:0] pat, input int n, input longint start);
    logic [7:0] pb;
    for (int i = 0; i < n; i++) begin
      pb = pat[8*i +: 8];
      if (!any_byte(pb) && pb != history[int'((start + i) % HIST_DEPTH)]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // This function takes one accepted byte into the predictor. It returns 1
  // when the byte produces a result request, and puts that result in rpt.
  // The candidate decided on this byte is the one whose full window ends here,
  // so candidates are decided in order and the first hit is the first match.
  function automatic bit next_result(input dws_pkg::in_t req, output dws_pkg::out_t rpt);
    int     l1, l2, off, span_end, span_low;
    longint x;
    bit     produce;
    rpt = '0;
    produce = 1'b0;
    history[scan_pos % HIST_DEPTH] = req.data_byte;
    if (!reported) begin
      l1 = eff_len(cfg_now.first_len);
      l2 = eff_len(cfg_now.second_len);
      off = $signed(cfg_now.second_off);
      span_end = (off + l2 > l1) ? off + l2 : l1;
      span_low = (off < 0) ? off : 0;
      x = longint'(scan_pos) - span_end + 1;
      if (l1 != 0 && l2 != 0 && span_end - span_low <= HIST_DEPTH && x >= 0 && x + off >= 0
          && window_fits({cfg_now.first_high, cfg_now.first_low}, l1, x)
          && window_fits({cfg_now.second_high, cfg_now.second_low}, l2, x + off)) begin
        rpt.found = 1'b1;
        rpt.match_position = x[31:0];
        reported = 1'b1;
        produce = 1'b1;
      end else if (req.region_end) begin
        produce = 1'b1;
      end
    end
    if (req.region_end) begin
      scan_pos = '0;
      reported = 1'b0;
    end else begin
      scan_pos = scan_pos + 1;
    end
    return produce;
  endfunction

  // The receiver toggles between ready stretches and stalls of random length.
  always @(posedge clk) begin
    int g;
    if (ready_left > 0) begin
      ready_left--;
    end else if (out_ready) begin
      g = pick_gap();
      if (g > 0) begin
        out_ready <= 1'b0;
        ready_left = g - 1;
      end else begin
        ready_left = $urandom_range(0, 7);
      end
    end else begin
      out_ready <= 1'b1;
      ready_left = $urandom_range(0, 7);
    end
  end

  // This block runs the predictor and the checker. Every signal here is read
  // right at the edge, before any of the edge's updates land. So each
  // handshake is judged on the values that the scanner itself sampled.
  always @(posedge clk) begin : scoreboard
    dws_pkg::out_t guess, want, seen;
    bit            made;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        made = next_result(in_data, guess);
        case (in_check)
          CHK_MODEL: if (made) awaited_results.push_back(guess);
          CHK_MISS: begin
            want = '0;
            awaited_results.push_back(want);
          end
          CHK_HIT: begin
            want.found = 1'b1;
            want.match_position = in_hit_pos;
            awaited_results.push_back(want);
          end
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        seen = out_data;
        if (awaited_results.size() == 0) begin
          $error("unexpected result: found %0b, match_position %0d",
                 seen.found, seen.match_position);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (seen.found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, seen.found);
            fail_count++;
          end
          if (seen.match_position !== want.match_position) begin
            $error("match_position: expected %0d, got %0d",
                   want.match_position, seen.match_position);
            fail_count++;
          end
        end
      end
    end
  end

  // One request goes out after a random gap. Valid then stays up until the
  // scanner takes the request.
  task automatic send_request(input dws_pkg::in_t r, input chk_kind_t k,
                              input logic [31:0] pos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= r;
    in_check   <= k;
    in_hit_pos <= pos;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  // This waits until every awaited result has arrived. The hold-off after that
  // covers a trailing byte that produced no result but may still be in flight.
  // A result that never comes is caught by the watchdog.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // A register write goes through a setup phase and then an access phase. It lands
  // on the edge where the access phase sees pready.
  task automatic write_reg(input dws_pkg::reg_idx_t idx, input logic [63:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_cfg(input dws_pkg::cfg_t c);
    write_reg(dws_pkg::REG_FIRST_LOW,   c.first_low);
    write_reg(dws_pkg::REG_FIRST_HIGH,  c.first_high);
    write_reg(dws_pkg::REG_FIRST_LEN,   64'(c.first_len));
    write_reg(dws_pkg::REG_SECOND_LOW,  c.second_low);
    write_reg(dws_pkg::REG_SECOND_HIGH, c.second_high);
    write_reg(dws_pkg::REG_SECOND_LEN,  64'(c.second_len));
    write_reg(dws_pkg::REG_SECOND_OFF,  64'(c.second_off));
    cfg_now = c;
  endtask

  // Region filler mostly comes from "ABC", so patterns built from the same
  // letters often match by chance.
  function automatic logic [7:0] filler_byte();
    if ($urandom_range(0, 9) < 7) return 8'h41 + 8'($urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic dws_pkg::cfg_t random_cfg();
    dws_pkg::cfg_t c;
    logic [127:0]  p;
    int            r, o;
    for (int n = 0; n < 2; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        p = {$urandom, $urandom, $urandom, $urandom};
      end else begin
        for (int i = 0; i < 16; i++) begin
          r = $urandom_range(0, 9);
          p[8*i +: 8] = (r == 0) ? dws_pkg::WILD_STAR :
                        (r == 1) ? dws_pkg::WILD_QUERY : filler_byte();
        end
      end
      r = $urandom_range(0, 19);
      if (n == 0) begin
        {c.first_high, c.first_low} = p;
        c.first_len = (r == 0) ? 5'd0 : (r == 1) ? 5'($urandom_range(17, 31)) :
                      (r == 2) ? 5'd16 : 5'($urandom_range(1, 6));
      end else begin
        {c.second_high, c.second_low} = p;
        c.second_len = (r == 0) ? 5'd0 : (r == 1) ? 5'($urandom_range(17, 31)) :
                       (r == 2) ? 5'd16 : 5'($urandom_range(1, 6));
      end
    end
    // The offset field can also hold values below -16, down to -32.
    r = $urandom_range(0, 9);
    o = (r == 0) ? -32 + 16 * int'($urandom_range(0, 1)) : (r == 1) ? 31 :
        (r == 2) ? int'($urandom_range(0, 47)) - 16 :
        int'($urandom_range(0, 12)) - 4;
    c.second_off = o[5:0];
    return c;
  endfunction

  // One whole region. Most regions have both patterns planted at a random
  // start. Wildcard positions keep their filler, and a region too short for
  // the window simply cuts the planted bytes off. Some planted regions then
  // get one byte overwritten, which usually breaks the match.
  task automatic random_region();
    int           n, l1, l2, off, x, k;
    logic [127:0] p1, p2;
    logic [7:0]   pb;
    logic [7:0]   bytes [];
    dws_pkg::in_t req;
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(31, 90) : $urandom_range(1, 30);
    bytes = new[n];
    foreach (bytes[i]) bytes[i] = filler_byte();
    if ($urandom_range(0, 9) < 7) begin
      l1 = eff_len(cfg_now.first_len);
      l2 = eff_len(cfg_now.second_len);
      off = $signed(cfg_now.second_off);
      p1 = {cfg_now.first_high, cfg_now.first_low};
      p2 = {cfg_now.second_high, cfg_now.second_low};
      x = ((off < 0) ? -off : 0) + $urandom_range(0, 8);
      for (k = 0; k < l1; k++) begin
        pb = p1[8*k +: 8];
        if (!any_byte(pb) && x + k < n) bytes[x + k] = pb;
      end
      for (k = 0; k < l2; k++) begin
        pb = p2[8*k +: 8];
        if (!any_byte(pb) && x + off + k < n) bytes[x + off + k] = pb;
      end
      if ($urandom_range(0, 3) == 0) bytes[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
    end
    for (k = 0; k < n; k++) begin
      req.data_byte  = bytes[k];
      req.region_end = (k == n - 1);
      send_request(req, CHK_MODEL, '0);
    end
  endtask

  initial begin : stimulus
    dws_pkg::in_t req;
    int           cur_phase;
    cur_phase = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The directed part starts from the reset values, then switches settings
    // between phases once the scanner has drained.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].phase != cur_phase) begin
        settle();
        program_cfg(dir_cfgs[dir_rows[i].phase]);
        cur_phase = dir_rows[i].phase;
      end
      req.data_byte  = dir_rows[i].data;
      req.region_end = dir_rows[i].last;
      send_request(req, dir_rows[i].kind, dir_rows[i].pos);
    end

    // In the random part every phase ends on a region boundary, so the
    // scanner is idle before each reprogram.
    while (sent_count < DIR_ROWS + RANDOM_ITEMS) begin
      settle();
      program_cfg(random_cfg());
      idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 8)) random_region();
    end

    settle();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // The watchdog allows several times the slowest legal run.
  initial begin : watchdog
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/dws_pkg.sv
rtl/dws_cfg_regs.sv
rtl/dws_tap_template.sv
rtl/dws_window_cmp.sv
rtl/dual_wildcard_signature_scan.sv
dv/dual_wildcard_signature_scan_tb.sv
